// ----- hdl/lpmd_pkg.sv -----
// lpmd_pkg: types and constants for the length-prefixed message deframer
// no dependencies; used by the deframer and its port checker
`timescale 1ns / 1ps

package lpmd_pkg;

    localparam int unsigned HEADER_BYTES = 4;

    localparam logic [31:0] MAX_LENGTH_RESET = 32'd65535;

    // result kinds on o_kind
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_BODY      = 2'd1;
    localparam logic [1:0] KIND_TOO_LONG  = 2'd2;
    localparam logic [1:0] KIND_TOO_SHORT = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_HALTED = 3'b100
    } t_phase;

endpackage

// ----- hdl/length_prefixed_message_deframer.sv -----
// length_prefixed_message_deframer: splits a byte stream into length-prefixed messages
// depends on lpmd_pkg
`timescale 1ns / 1ps

//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+------------------------------
//  input     | in        | i_in_valid / o_in_ready  | i_stream_byte
//  result    | out       | o_out_valid / i_out_ready| o_kind, o_value, o_last
//  config    | in        | i_cfg_valid / o_cfg_ready| i_max_length
//
//  one item per cycle sustained while results are drained; an item that gives a result
//  passes through the input register, then the result register
//  synchronous active-low reset: header phase, empty pipeline, max_length 65535
//  a stalled result holds the result register; the input register keeps taking items
//  while the result register is empty or being drained in the same cycle
//  after an error result the block drops every item until reset

module length_prefixed_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_value,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_max_length
);

    logic [31:0]           r_max_length;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    lpmd_pkg::t_phase      r_phase,     n_phase;
    logic [1:0]            r_hdr_count, n_hdr_count;
    logic [23:0]           r_len_low,   n_len_low;
    logic [31:0]           r_remaining, n_remaining;
    logic                  r_out_valid;
    logic [1:0]            r_kind,      n_kind;
    logic [31:0]           r_value,     n_value;
    logic                  r_last,      n_last;
    logic                  n_result;

    logic        out_free;
    logic        s1_go;
    logic [31:0] full_len;
    logic [31:0] rem_dec;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_go       = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    assign full_len = {r_in_byte, r_len_low};
    assign rem_dec  = r_remaining - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_count = r_hdr_count;
        n_len_low   = r_len_low;
        n_remaining = r_remaining;
        n_result    = 1'b0;
        n_kind      = lpmd_pkg::KIND_HEADER;
        n_value     = '0;
        n_last      = 1'b0;
        unique case (r_phase)
            lpmd_pkg::PH_HEADER: begin
                unique case (r_hdr_count)
                    2'd0: n_len_low[7:0]   = r_in_byte;
                    2'd1: n_len_low[15:8]  = r_in_byte;
                    2'd2: n_len_low[23:16] = r_in_byte;
                    default: n_len_low     = '0;
                endcase
                if (r_hdr_count != 2'd3) begin
                    n_hdr_count = r_hdr_count + 2'd1;
                end else begin
                    n_hdr_count = 2'd0;
                    n_result    = 1'b1;
                    n_last      = 1'b1;
                    // too-long check wins when max_length is below the header size
                    priority if (full_len > r_max_length) begin
                        n_phase = lpmd_pkg::PH_HALTED;
                        n_kind  = lpmd_pkg::KIND_TOO_LONG;
                    end else if (full_len < 32'(lpmd_pkg::HEADER_BYTES)) begin
                        n_phase = lpmd_pkg::PH_HALTED;
                        n_kind  = lpmd_pkg::KIND_TOO_SHORT;
                    end else if (full_len == 32'(lpmd_pkg::HEADER_BYTES)) begin
                        n_value = full_len;
                    end else begin
                        n_value     = full_len;
                        n_last      = 1'b0;
                        n_remaining = full_len - 32'(lpmd_pkg::HEADER_BYTES);
                        n_phase     = lpmd_pkg::PH_BODY;
                    end
                end
            end
            lpmd_pkg::PH_BODY: begin
                n_remaining = rem_dec;
                n_result    = 1'b1;
                n_kind      = lpmd_pkg::KIND_BODY;
                n_value     = {24'd0, r_in_byte};
                n_last      = (rem_dec == 32'd0);
                if (rem_dec == 32'd0) begin
                    n_phase = lpmd_pkg::PH_HEADER;
                end
            end
            default: begin
                // halted: item dropped
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= lpmd_pkg::MAX_LENGTH_RESET;
            r_in_valid   <= 1'b0;
            r_phase      <= lpmd_pkg::PH_HEADER;
            r_hdr_count  <= 2'd0;
            r_len_low    <= '0;
            r_remaining  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_length <= i_max_length;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_go) begin
                r_phase     <= n_phase;
                r_hdr_count <= n_hdr_count;
                r_len_low   <= n_len_low;
                r_remaining <= n_remaining;
            end
            if (s1_go && n_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_stream_byte;
        end
        if (s1_go && n_result) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

// ----- hdl/lpmd_checker.sv -----
// lpmd_checker: port-level assertions for the deframer, bound to the top level
// depends on lpmd_pkg and length_prefixed_message_deframer
`timescale 1ns / 1ps

module lpmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_value,
    input logic        o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_value) && $stable(o_last))
        else $error("result changed while stalled");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == lpmd_pkg::KIND_TOO_LONG ||
                        o_kind == lpmd_pkg::KIND_TOO_SHORT) |->
            o_value == 32'd0 && o_last)
        else $error("error item with nonzero value or last clear");

    // halted after an error item leaves
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_kind == lpmd_pkg::KIND_TOO_LONG ||
                                       o_kind == lpmd_pkg::KIND_TOO_SHORT) |=>
            !o_out_valid)
        else $error("item after error");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lpmd_pkg::KIND_HEADER |->
            o_value >= 32'd4 && (o_last == (o_value == 32'd4)))
        else $error("bad header item");

    a_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lpmd_pkg::KIND_BODY |-> o_value[31:8] == 24'd0)
        else $error("body item wider than a byte");

endmodule

bind length_prefixed_message_deframer lpmd_checker u_lpmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_value     (o_value),
    .o_last      (o_last)
);
